/* design/sbx_pkg.sv */
// Shared types, constants and helpers for the Sobel X gradient unit.
package sbx_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int WSUM_W     = PIX_W + 2;
  localparam int GRAD_W     = WSUM_W + 1;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_CELLS  = 2;

  typedef logic [PIX_W-1:0]         pixel_t;
  typedef logic [WSUM_W-1:0]        wsum_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [COL_W-1:0]         col_idx_t;
  typedef logic [ROW_W-1:0]         row_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // One window column, top row first.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  // Stage between RAM read and window update.
  typedef struct packed {
    pixel_t   pixel;
    col_idx_t col;
    logic     emit;
    logic     frame_end;
  } s1_t;

  function automatic wsum_t col_wsum(col_t c);
    return {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
  endfunction

  function automatic col_idx_t width_last(logic [FW_W-1:0] v);
    if (v < FW_W'(3)) begin
      return COL_W'(2);
    end else if (v > FW_W'(MAX_WIDTH)) begin
      return COL_W'(MAX_WIDTH - 1);
    end
    return COL_W'(v - FW_W'(1));
  endfunction

  function automatic row_idx_t height_last(logic [FH_W-1:0] v);
    if (v < FH_W'(3)) begin
      return ROW_W'(2);
    end else if (v > FH_W'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end
    return ROW_W'(v - FH_W'(1));
  endfunction

endpackage

/* design/sbx_if.sv */
// Stream interfaces for pixel input beats and gradient result beats.
interface sbx_pixel_if;
  logic              valid;
  logic              ready;
  sbx_pkg::pixel_t   pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sbx_grad_if;
  logic              valid;
  logic              ready;
  sbx_pkg::grad_t    gradient;
  logic              frame_end;
  modport source (output valid, output gradient, output frame_end, input ready);
  modport sink   (input valid, input gradient, input frame_end, output ready);
endinterface

/* design/sobel_x_3x3_gradient_unit.sv */
// Top level of the Sobel X 3x3 gradient unit.
// Path: pixel beat, stage s1 register, output register. One line RAM read and write
// each cycle set the throughput: one pixel per cycle, unless the output stalls.
// Rows 0 and 1 and columns 0 and 1 of each frame produce no result beat.
// Synchronous active-low reset clears counters and valids; frame size returns to 32x32.
// No clearing pass: line RAM contents are only read for border pixels until written.
module sobel_x_3x3_gradient_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  sbx_pixel_if.sink                           in_chan,
  sbx_grad_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [sbx_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sbx_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sbx_pkg::*;

  localparam int LINE_W = 2 * PIX_W;

  col_idx_t wlast_r, wlast_nxt;
  row_idx_t hlast_r, hlast_nxt;
  col_idx_t col_r, col_nxt;
  row_idx_t row_r, row_nxt;
  s1_t      s1_r, s1_nxt;
  logic     s1_valid_r, s1_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  grad_t    out_grad_r, out_grad_nxt;
  logic     out_fend_r, out_fend_nxt;

  logic              cfg_hit;
  logic              in_fire;
  logic              s1_fire;
  logic [LINE_W-1:0] rd_line;
  logic [LINE_W-1:0] wr_line;
  col_t              col_q [NUM_CELLS+1];
  grad_t             grad_calc;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_hit = 1'b1;
        default:                           cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  wlast_nxt = width_last(cfg_data[FW_W-1:0]);
        REG_FRAME_HEIGHT: hlast_nxt = height_last(cfg_data[FH_W-1:0]);
        default: begin
          wlast_nxt = wlast_r;
          hlast_nxt = hlast_r;
        end
      endcase
    end
  end

  // Handshakes
  assign s1_fire = s1_valid_r && (!s1_r.emit || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire = in_chan.valid && in_chan.ready;

  // Advance raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_nxt       = s1_r;
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_nxt.pixel     = in_chan.pixel;
      s1_nxt.col       = col_r;
      s1_nxt.emit      = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_nxt.frame_end = (row_r == hlast_r) && (col_r == wlast_r);
      s1_valid_nxt     = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Line RAM entry: two rows above in the high byte, row above in the low byte
  assign wr_line = {rd_line[PIX_W-1:0], s1_r.pixel};

  sbx_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_r.col),
    .wr_data (wr_line),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_line)
  );

  assign col_q[0] = '{top: rd_line[LINE_W-1:PIX_W], mid: rd_line[PIX_W-1:0],
                      bot: s1_r.pixel};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sbx_col_cell u_cell (
      .clk      (clk),
      .shift_en (s1_fire),
      .col_in   (col_q[i]),
      .col_out  (col_q[i+1])
    );
  end

  assign grad_calc = $signed({1'b0, col_wsum(col_q[NUM_CELLS])})
                   - $signed({1'b0, col_wsum(col_q[0])});

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_grad_nxt  = out_grad_r;
    out_fend_nxt  = out_fend_r;
    if (s1_fire && s1_r.emit) begin
      out_valid_nxt = 1'b1;
      out_grad_nxt  = grad_calc;
      out_fend_nxt  = s1_r.frame_end;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r     <= COL_W'(31);
      hlast_r     <= ROW_W'(31);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wlast_r     <= wlast_nxt;
      hlast_r     <= hlast_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_grad_r <= out_grad_nxt;
    out_fend_r <= out_fend_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.gradient  = out_grad_r;
  assign out_chan.frame_end = out_fend_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column counter beyond row width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hlast_r)
    else $error("row counter beyond frame height");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0) && (row_r == '0))
    else $error("frame did not restart after register write");

  a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.emit |=> out_valid_r)
    else $error("interior pixel did not yield a result beat");

  a_fend_corner: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (row_r == hlast_r) && (col_r == wlast_r) |=> s1_r.emit && s1_r.frame_end)
    else $error("last pixel of frame not flagged");
endmodule

/* design/sbx_line_ram.sv */
// Simple dual-port line RAM with registered read data.
module sbx_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

/* design/sbx_col_cell.sv */
// One window column cell: holds three pixels and hands them on at each shift.
module sbx_col_cell (
  input  logic         clk,
  input  logic         shift_en,
  input  sbx_pkg::col_t col_in,
  output sbx_pkg::col_t col_out
);
  import sbx_pkg::*;

  col_t col_r;
  col_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  assign col_out = col_r;
endmodule
